>>> hw/rtl/rebq_pkg.sv
package rebq_pkg;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 16;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_DEBOUNCE_TICKS   = 2'd0,
        CFG_RELAX_TICKS      = 2'd1,
        CFG_LONG_PRESS_TICKS = 2'd2
    } cfg_index_t;

    localparam logic [9:0]  DEBOUNCE_RESET   = 10'd50;
    localparam logic [9:0]  RELAX_RESET      = 10'd100;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd3000;

    localparam logic [10:0] QUIET_MAX = 11'h7FF;

    // sticky event bit positions
    localparam int EV_CW     = 0;
    localparam int EV_CCW    = 1;
    localparam int EV_PUSH   = 2;
    localparam int EV_MASTER = 3;
    localparam int EV_B1     = 4;
    localparam int EV_B2     = 5;

    localparam int PEND_ROTATE = 0;
    localparam int PEND_PUSH   = 1;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_CW   = 2'd1,
        STEP_CCW  = 2'd2
    } step_t;

    typedef struct packed {
        logic [1:0] enc_ab;
        logic       enc_button;
        logic       button_one;
        logic       button_two;
        logic [5:0] clear_events;
        logic       clear_pending;
    } poll_t;

    typedef struct packed {
        logic       rotated_cw;
        logic       rotated_ccw;
        logic       rotary_pushed;
        logic       long_press_reset;
        logic       button_one_pushed;
        logic       button_two_pushed;
        logic [1:0] encoder_pending;
        logic       button_one_level;
        logic       button_two_level;
    } result_t;

    // transition table indexed by {previous_ab, enc_ab}; only moves out of the 00 detent count
    function automatic step_t step_decode(input logic [3:0] idx);
        step_t s;
        case (idx)
            4'h1:    s = STEP_CCW;
            4'h2:    s = STEP_CW;
            default: s = STEP_NONE;
        endcase
        return s;
    endfunction

endpackage

>>> hw/rtl/rebq_if.sv
interface rebq_poll_if;
    import rebq_pkg::*;
    logic  valid;
    logic  ready;
    poll_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rebq_result_if;
    import rebq_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/rebq_debounce.sv
module rebq_debounce
    import rebq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       raw,
    input  logic [9:0] debounce_ticks,
    output logic       level_next,
    output logic       press
);

    logic        stable_reg;
    logic        last_raw_reg;
    logic [10:0] quiet_reg;
    logic [10:0] quiet_next;
    logic        take;

    always_comb
    begin
        if (raw != last_raw_reg)
        begin
            quiet_next = '0;
        end
        else if (quiet_reg < QUIET_MAX)
        begin
            quiet_next = quiet_reg + 11'd1;
        end
        else
        begin
            quiet_next = quiet_reg;
        end
        take       = (quiet_next > {1'b0, debounce_ticks}) && (raw != stable_reg);
        level_next = take ? raw : stable_reg;
        press      = take && !raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg   <= 1'b1;
            last_raw_reg <= 1'b1;
            quiet_reg    <= '0;
        end
        else if (en)
        begin
            stable_reg   <= level_next;
            last_raw_reg <= raw;
            quiet_reg    <= quiet_next;
        end
    end

endmodule

>>> hw/rtl/rotary_encoder_button_qualifier_core.sv
// channel  | dir  | payload   | notes
// poll     | sink | poll_t    | one 1 ms poll tick per item
// result   | src  | result_t  | one result item per poll item
// cfg      | in   | 16b write | debounce, relax, long-press tick counts
//
// an item is captured in the poll register, qualified from there and written
// with the encoder/button state into the result register, one item per cycle
// sustained while the result is not stalled. reset clears all but the data
// registers, puts both debounced levels at released and loads the register
// defaults. a stalled result only holds the stages behind it.
module rotary_encoder_button_qualifier_core
    import rebq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    rebq_poll_if.sink                poll,
    rebq_result_if.source            result,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_wdata
);

    logic [9:0]  debounce_ticks_reg;
    logic [9:0]  relax_ticks_reg;
    logic [15:0] long_press_ticks_reg;

    poll_t       poll_reg;
    logic        poll_valid_reg;
    result_t     result_reg;
    logic        result_valid_reg;
    logic        advance;

    logic [1:0]  prev_ab_reg;
    logic [1:0]  prev_ab_next;
    logic [5:0]  event_flags_reg;
    logic [5:0]  event_flags_next;
    logic [1:0]  pending_reg;
    logic [1:0]  pending_next;
    logic [9:0]  relax_count_reg;
    logic [9:0]  relax_count_next;
    logic [16:0] hold_count_reg;
    logic [16:0] hold_count_next;

    logic        b1_level_next;
    logic        b1_press;
    logic        b2_level_next;
    logic        b2_press;
    step_t       step;

    assign advance      = poll_valid_reg && (!result_valid_reg || result.ready);
    assign poll.ready   = !poll_valid_reg || advance;
    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg   <= DEBOUNCE_RESET;
            relax_ticks_reg      <= RELAX_RESET;
            long_press_ticks_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= cfg_wdata[9:0];
                CFG_RELAX_TICKS:      relax_ticks_reg      <= cfg_wdata[9:0];
                CFG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    // poll register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
        end
        else if (poll.ready)
        begin
            poll_valid_reg <= poll.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            poll_reg <= poll.data;
        end
    end

    rebq_debounce u_button_one (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (advance),
        .raw            (poll_reg.button_one),
        .debounce_ticks (debounce_ticks_reg),
        .level_next     (b1_level_next),
        .press          (b1_press)
    );

    rebq_debounce u_button_two (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (advance),
        .raw            (poll_reg.button_two),
        .debounce_ticks (debounce_ticks_reg),
        .level_next     (b2_level_next),
        .press          (b2_press)
    );

    assign step = step_decode({prev_ab_reg, poll_reg.enc_ab});

    // acknowledges first, then the encoder while nothing is pending, then the panel buttons
    always_comb
    begin
        event_flags_next = event_flags_reg & ~poll_reg.clear_events;
        pending_next     = poll_reg.clear_pending ? 2'b00 : pending_reg;
        prev_ab_next     = prev_ab_reg;
        relax_count_next = relax_count_reg;
        hold_count_next  = hold_count_reg;

        if (pending_next == 2'b00)
        begin
            prev_ab_next = poll_reg.enc_ab;
            case (step)
                STEP_CW:
                begin
                    event_flags_next[EV_CW]   = 1'b1;
                    pending_next[PEND_ROTATE] = 1'b1;
                end
                STEP_CCW:
                begin
                    event_flags_next[EV_CCW]  = 1'b1;
                    pending_next[PEND_ROTATE] = 1'b1;
                end
                default: ;
            endcase

            if (!poll_reg.enc_button && relax_count_reg == '0)
            begin
                relax_count_next          = relax_ticks_reg;
                event_flags_next[EV_PUSH] = 1'b1;
                pending_next[PEND_PUSH]   = 1'b1;
            end
            else if (poll_reg.enc_button)
            begin
                if (relax_count_reg != '0)
                begin
                    relax_count_next = relax_count_reg - 10'd1;
                end
                hold_count_next = '0;
            end
            else if (hold_count_reg > {1'b0, long_press_ticks_reg})
            begin
                event_flags_next[EV_MASTER] = 1'b1;
                hold_count_next             = '0;
            end
            else
            begin
                hold_count_next = hold_count_reg + 17'd1;
            end
        end

        event_flags_next[EV_B1] = event_flags_next[EV_B1] | b1_press;
        event_flags_next[EV_B2] = event_flags_next[EV_B2] | b2_press;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ab_reg      <= '0;
            event_flags_reg  <= '0;
            pending_reg      <= '0;
            relax_count_reg  <= '0;
            hold_count_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                prev_ab_reg      <= prev_ab_next;
                event_flags_reg  <= event_flags_next;
                pending_reg      <= pending_next;
                relax_count_reg  <= relax_count_next;
                hold_count_reg   <= hold_count_next;
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.rotated_cw        <= event_flags_next[EV_CW];
            result_reg.rotated_ccw       <= event_flags_next[EV_CCW];
            result_reg.rotary_pushed     <= event_flags_next[EV_PUSH];
            result_reg.long_press_reset  <= event_flags_next[EV_MASTER];
            result_reg.button_one_pushed <= event_flags_next[EV_B1];
            result_reg.button_two_pushed <= event_flags_next[EV_B2];
            result_reg.encoder_pending   <= pending_next;
            result_reg.button_one_level  <= b1_level_next;
            result_reg.button_two_level  <= b2_level_next;
        end
    end

    // encoder state is frozen while a pending code survives the acknowledge
    a_frozen_encoder: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !poll_reg.clear_pending && pending_reg != 2'b00
        |=> $stable(prev_ab_reg) && $stable(relax_count_reg) && $stable(hold_count_reg))
        else $error("encoder state moved while pending");

    // a shown result mirrors the cw, long-press and button-two sticky flags and the pending code it came from
    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |->
            result_reg.rotated_cw == event_flags_reg[EV_CW] &&
            result_reg.long_press_reset == event_flags_reg[EV_MASTER] &&
            result_reg.button_two_pushed == event_flags_reg[EV_B2] &&
            result_reg.encoder_pending == pending_reg)
        else $error("result out of step with sticky state");

    a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hold_count_reg <= 17'h10000)
        else $error("hold count out of range");

    // a processed item always lands in the result register
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("processed item lost");

    a_poll_kept: assert property (@(posedge clk) disable iff (!rst_n)
        poll_valid_reg && !advance |=> poll_valid_reg && $stable(poll_reg))
        else $error("waiting item dropped or overwritten");

endmodule

>>> tb/rotary_encoder_button_qualifier_core_tb.sv
`timescale 1ns / 1ps

module rotary_encoder_button_qualifier_core_tb;
    import rebq_pkg::*;

    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;

    // {previous_ab, enc_ab} moves out of the 00 detent
    localparam logic [3:0] HIST_CCW = 4'b0001;
    localparam logic [3:0] HIST_CW  = 4'b0010;

    localparam logic [1:0] ENC_GRAY [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

    typedef enum int {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_NONE
    } idle_mode_t;

    typedef struct {
        bit      retime;
        poll_t   item;
        bit      typed;
        result_t want;
    } poll_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    logic [CfgDataWidth-1:0] cfg_wdata;

    rebq_poll_if   poll ();
    rebq_result_if result ();

    rotary_encoder_button_qualifier_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .poll      (poll),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // qualifier state as the block should hold it
    logic [9:0]  deb_cfg;
    logic [9:0]  relax_cfg;
    logic [15:0] long_cfg;
    logic [1:0]  prev_ab;
    logic [5:0]  ev_flags;
    logic [1:0]  enc_pend;
    logic [9:0]  relax_left;
    logic [16:0] held_ticks;
    logic        btn_stable [2];
    logic        btn_last [2];
    logic [10:0] btn_quiet [2];

    result_t    due_results [$];
    poll_row_t  directed_rows [$];
    idle_mode_t idle_mode;
    bit         drive_typed;
    result_t    drive_want;
    bit         hold_encoder_button;

    int n_items;
    int n_results;
    int n_errors;
    int n_settings;
    int stall_cycles;
    int raised_cnt [6];

    // stimulus shaping state
    int enc_pos;
    bit ebtn_lvl;
    int ebtn_left;
    bit pb_lvl [2];
    int pb_left [2];

    function automatic result_t pack_result(input logic [5:0] flags, input logic [1:0] pend,
                                            input logic l1, input logic l2);
        result_t r;
        r.rotated_cw        = flags[EV_CW];
        r.rotated_ccw       = flags[EV_CCW];
        r.rotary_pushed     = flags[EV_PUSH];
        r.long_press_reset  = flags[EV_MASTER];
        r.button_one_pushed = flags[EV_B1];
        r.button_two_pushed = flags[EV_B2];
        r.encoder_pending   = pend;
        r.button_one_level  = l1;
        r.button_two_level  = l2;
        return r;
    endfunction

    function automatic void raise_event(input int k);
        if (!ev_flags[k])
            raised_cnt[k]++;
        ev_flags[k] = 1'b1;
    endfunction

    function automatic result_t qualify_tick(input poll_t p);
        logic [1:0] raw;
        logic [3:0] hist;
        raw = {p.button_two, p.button_one};
        if (p.clear_pending)
            enc_pend = '0;
        ev_flags &= ~p.clear_events;

        if (enc_pend == 2'b00)
        begin
            hist    = {prev_ab, p.enc_ab};
            prev_ab = p.enc_ab;
            if (hist == HIST_CCW)
            begin
                raise_event(EV_CCW);
                enc_pend[PEND_ROTATE] = 1'b1;
            end
            else if (hist == HIST_CW)
            begin
                raise_event(EV_CW);
                enc_pend[PEND_ROTATE] = 1'b1;
            end

            if (!p.enc_button && relax_left == '0)
            begin
                relax_left = relax_cfg;
                raise_event(EV_PUSH);
                enc_pend[PEND_PUSH] = 1'b1;
            end
            else if (p.enc_button)
            begin
                if (relax_left != '0)
                    relax_left--;
                held_ticks = '0;
            end
            else if (held_ticks > {1'b0, long_cfg})
            begin
                raise_event(EV_MASTER);
                held_ticks = '0;
            end
            else
                held_ticks++;
        end

        for (int i = 0; i < 2; i++)
        begin
            if (raw[i] != btn_last[i])
                btn_quiet[i] = '0;
            else if (btn_quiet[i] != QUIET_MAX)
                btn_quiet[i]++;
            if (btn_quiet[i] > {1'b0, deb_cfg} && raw[i] != btn_stable[i])
            begin
                btn_stable[i] = raw[i];
                if (!raw[i])
                    raise_event(EV_B1 + i);
            end
            btn_last[i] = raw[i];
        end

        return pack_result(ev_flags, enc_pend, btn_stable[0], btn_stable[1]);
    endfunction

    function automatic poll_row_t row(input bit retime, input logic [1:0] ab, input bit eb,
                                      input bit b1, input bit b2, input logic [5:0] clr,
                                      input bit cp, input bit typed, input logic [5:0] flags,
                                      input logic [1:0] pend, input bit l1, input bit l2);
        poll_row_t r;
        r.retime             = retime;
        r.item.enc_ab        = ab;
        r.item.enc_button    = eb;
        r.item.button_one    = b1;
        r.item.button_two    = b2;
        r.item.clear_events  = clr;
        r.item.clear_pending = cp;
        r.typed              = typed;
        r.want               = pack_result(flags, pend, l1, l2);
        return r;
    endfunction

    // mostly legal quadrature walks and bounce-then-hold button runs, with some noise
    function automatic poll_t next_poll();
        poll_t p;
        int    r;
        int    span;
        r = $urandom_range(99);
        if (r < 8)
            p.enc_ab = 2'($urandom_range(3));
        else
        begin
            if (r < 40)
                enc_pos = (enc_pos + 1) % 4;
            else if (r < 70)
                enc_pos = (enc_pos + 3) % 4;
            p.enc_ab = ENC_GRAY[enc_pos];
        end

        if (ebtn_left == 0)
        begin
            ebtn_lvl = !ebtn_lvl;
            span = ebtn_lvl ? int'(relax_cfg) : int'(long_cfg);
            if (span > 600)
                span = 600;
            ebtn_left = ($urandom_range(3) == 0) ? $urandom_range(1, 3)
                                                 : $urandom_range(1, span + 4);
        end
        ebtn_left--;
        p.enc_button = hold_encoder_button ? 1'b0 : ebtn_lvl;

        for (int i = 0; i < 2; i++)
        begin
            if (pb_left[i] == 0)
            begin
                pb_lvl[i]  = !pb_lvl[i];
                pb_left[i] = ($urandom_range(1) == 0) ? $urandom_range(1, 3)
                                                      : int'(deb_cfg) + $urandom_range(1, 8);
            end
            pb_left[i]--;
        end
        p.button_one = pb_lvl[0];
        p.button_two = pb_lvl[1];

        if (hold_encoder_button)
            p.clear_pending = ($urandom_range(63) != 0);
        else
            p.clear_pending = ($urandom_range(9) < 7);
        p.clear_events = ($urandom_range(1) == 0) ? 6'd0 : 6'($urandom_range(63));
        return p;
    endfunction

    function automatic int tx_gap_pct();
        case (idle_mode)
            IDLE_RX_HEAVY: return 10;
            IDLE_TX_HEAVY: return 78;
            default:       return 0;
        endcase
    endfunction

    function automatic int rx_stall_pct();
        case (idle_mode)
            IDLE_RX_HEAVY: return 78;
            IDLE_TX_HEAVY: return 10;
            default:       return 0;
        endcase
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            n_errors++;
            if (n_errors <= 10)
                $display("result %0d: %s expected %0d got %0d", n_results, name, want, got);
        end
    endtask

    task automatic send_poll(input poll_t item);
        while ($urandom_range(99) < tx_gap_pct())
        begin
            poll.valid <= 1'b0;
            @(negedge clk);
        end
        poll.valid <= 1'b1;
        poll.data  <= item;
        @(posedge clk);
        while (!poll.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic finish_phase();
        poll.valid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_timing(input logic [9:0] deb, input logic [9:0] rlx,
                                  input logic [15:0] lng);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEBOUNCE_TICKS;
        cfg_wdata <= {6'd0, deb};
        @(negedge clk);
        cfg_index <= CFG_RELAX_TICKS;
        cfg_wdata <= {6'd0, rlx};
        @(negedge clk);
        cfg_index <= CFG_LONG_PRESS_TICKS;
        cfg_wdata <= lng;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        deb_cfg   = deb;
        relax_cfg = rlx;
        long_cfg  = lng;
        n_settings++;
    endtask

    task automatic run_random(input logic [9:0] deb, input logic [9:0] rlx,
                              input logic [15:0] lng, input int n_polls,
                              input idle_mode_t mode, input bit hold);
        finish_phase();
        program_timing(deb, rlx, lng);
        idle_mode           = mode;
        hold_encoder_button = hold;
        repeat (n_polls) send_poll(next_poll());
    endtask

    always @(negedge clk)
        result.ready <= ($urandom_range(99) >= rx_stall_pct());

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (poll.valid && poll.ready)
            begin
                want = qualify_tick(poll.data);
                if (drive_typed)
                    want = drive_want;
                due_results.push_back(want);
                n_items++;
            end
            if (result.valid && result.ready)
            begin
                n_results++;
                got = result.data;
                if (due_results.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("result %0d: no item outstanding for it", n_results);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("rotated_cw", want.rotated_cw, got.rotated_cw);
                    check_field("rotated_ccw", want.rotated_ccw, got.rotated_ccw);
                    check_field("rotary_pushed", want.rotary_pushed, got.rotary_pushed);
                    check_field("long_press_reset", want.long_press_reset,
                                got.long_press_reset);
                    check_field("button_one_pushed", want.button_one_pushed,
                                got.button_one_pushed);
                    check_field("button_two_pushed", want.button_two_pushed,
                                got.button_two_pushed);
                    check_field("encoder_pending", want.encoder_pending, got.encoder_pending);
                    check_field("button_one_level", want.button_one_level,
                                got.button_one_level);
                    check_field("button_two_level", want.button_two_level,
                                got.button_two_level);
                end
            end

            if ((poll.valid && poll.ready) || (result.valid && result.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("no handshake for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, due_results.size());
                $display("rotary_encoder_button_qualifier_core_tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_DEBOUNCE_TICKS;
        cfg_wdata    = '0;
        poll.valid   = 1'b0;
        poll.data    = '0;
        result.ready = 1'b0;

        deb_cfg    = DEBOUNCE_RESET;
        relax_cfg  = RELAX_RESET;
        long_cfg   = LONG_PRESS_RESET;
        prev_ab    = '0;
        ev_flags   = '0;
        enc_pend   = '0;
        relax_left = '0;
        held_ticks = '0;
        for (int i = 0; i < 2; i++)
        begin
            btn_stable[i] = 1'b1;
            btn_last[i]   = 1'b1;
            btn_quiet[i]  = '0;
            pb_lvl[i]     = 1'b1;
            pb_left[i]    = 0;
        end
        for (int k = 0; k < 6; k++)
            raised_cnt[k] = 0;
        enc_pos             = 0;
        ebtn_lvl            = 1'b1;
        ebtn_left           = 0;
        hold_encoder_button = 1'b0;
        drive_typed         = 1'b0;
        drive_want          = '0;
        idle_mode           = IDLE_RX_HEAVY;
        n_items             = 0;
        n_results           = 0;
        n_errors            = 0;
        n_settings          = 1;
        stall_cycles        = 0;

        // reset timing: quadrature steps, pending freeze and the clear masks
        directed_rows.push_back(row(0, 2'b00, 1, 1, 1, 6'h00, 0, 1, 6'b000000, 2'b00, 1, 1));
        directed_rows.push_back(row(0, 2'b10, 1, 1, 1, 6'h00, 0, 1, 6'b000001, 2'b01, 1, 1));
        directed_rows.push_back(row(0, 2'b01, 1, 1, 1, 6'h00, 0, 1, 6'b000001, 2'b01, 1, 1));
        directed_rows.push_back(row(0, 2'b00, 1, 1, 1, 6'h01, 1, 1, 6'b000000, 2'b00, 1, 1));
        directed_rows.push_back(row(0, 2'b01, 1, 1, 1, 6'h00, 0, 1, 6'b000010, 2'b01, 1, 1));
        directed_rows.push_back(row(0, 2'b11, 1, 0, 0, 6'h02, 1, 1, 6'b000000, 2'b00, 1, 1));
        directed_rows.push_back(row(0, 2'b00, 1, 0, 0, 6'h00, 0, 1, 6'b000000, 2'b00, 1, 1));
        directed_rows.push_back(row(0, 2'b10, 1, 0, 0, 6'h00, 0, 1, 6'b000001, 2'b01, 1, 1));
        directed_rows.push_back(row(0, 2'b00, 1, 0, 0, 6'h3F, 0, 1, 6'b000000, 2'b01, 1, 1));
        directed_rows.push_back(row(0, 2'b00, 1, 1, 1, 6'h3F, 1, 1, 6'b000000, 2'b00, 1, 1));
        // step raised in the same tick its clear bit is set
        directed_rows.push_back(row(0, 2'b10, 1, 1, 1, 6'h01, 0, 1, 6'b000001, 2'b01, 1, 1));
        directed_rows.push_back(row(0, 2'b11, 1, 1, 1, 6'h00, 1, 1, 6'b000001, 2'b00, 1, 1));
        directed_rows.push_back(row(0, 2'b00, 1, 1, 1, 6'h00, 0, 0, '0, '0, 0, 0));
        directed_rows.push_back(row(0, 2'b11, 1, 1, 1, 6'h00, 0, 0, '0, '0, 0, 0));
        // zero debounce, relax and long press: every pressed tick with nothing pending is a new push
        directed_rows.push_back(row(1, 2'b11, 0, 1, 1, 6'h3F, 1, 0, '0, '0, 0, 0));
        directed_rows.push_back(row(0, 2'b11, 0, 1, 1, 6'h04, 1, 0, '0, '0, 0, 0));
        directed_rows.push_back(row(0, 2'b11, 0, 0, 1, 6'h00, 0, 0, '0, '0, 0, 0));
        directed_rows.push_back(row(0, 2'b11, 0, 0, 1, 6'h00, 0, 0, '0, '0, 0, 0));
        directed_rows.push_back(row(0, 2'b11, 1, 1, 0, 6'h00, 1, 0, '0, '0, 0, 0));
        directed_rows.push_back(row(0, 2'b11, 1, 1, 0, 6'h00, 0, 0, '0, '0, 0, 0));
        directed_rows.push_back(row(0, 2'b00, 1, 1, 1, 6'h3F, 1, 0, '0, '0, 0, 0));
        directed_rows.push_back(row(0, 2'b00, 1, 1, 1, 6'h00, 0, 0, '0, '0, 0, 0));

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].retime)
            begin
                finish_phase();
                program_timing(10'd0, 10'd0, 16'd0);
            end
            drive_typed = directed_rows[k].typed;
            drive_want  = directed_rows[k].want;
            send_poll(directed_rows[k].item);
        end
        drive_typed = 1'b0;

        run_random(10'd3, 10'd2, 16'd5, 400, IDLE_RX_HEAVY, 1'b0);
        run_random(10'd0, 10'd0, 16'd0, 300, IDLE_TX_HEAVY, 1'b0);
        run_random(10'd20, 10'd50, 16'd40, 400, IDLE_TX_HEAVY, 1'b0);
        // encoder button held through a few long-press windows at the widest debounce
        run_random(10'd1023, 10'd1023, 16'd30, 80, IDLE_NONE, 1'b1);
        finish_phase();

        if (due_results.size() != 0)
        begin
            n_errors += due_results.size();
            $display("%0d results never arrived", due_results.size());
        end

        $display("%0d poll items over %0d timing settings, %0d results checked",
                 n_items, n_settings, n_results);
        $display("events raised: cw %0d ccw %0d push %0d long press %0d b1 %0d b2 %0d",
                 raised_cnt[EV_CW], raised_cnt[EV_CCW], raised_cnt[EV_PUSH],
                 raised_cnt[EV_MASTER], raised_cnt[EV_B1], raised_cnt[EV_B2]);
        if (n_errors == 0)
            $display("rotary_encoder_button_qualifier_core_tb: done, clean");
        else
            $display("rotary_encoder_button_qualifier_core_tb: done, errors");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/rebq_pkg.sv
hw/rtl/rebq_if.sv
hw/rtl/rebq_debounce.sv
hw/rtl/rotary_encoder_button_qualifier_core.sv
tb/rotary_encoder_button_qualifier_core_tb.sv
